### rtl/variable_width_adpcm_decoder_defines.svh
// Assertion macros shared by the ADPCM decoder RTL.
`ifndef VARIABLE_WIDTH_ADPCM_DECODER_DEFINES_SVH
`define VARIABLE_WIDTH_ADPCM_DECODER_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define VWAD_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, sampled on clk_i, off during reset.
`define VWAD_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### rtl/vwad_pkg.sv
// Types, constants and tables of the variable-width ADPCM decoder.
package vwad_pkg;

  localparam int NumChannels = 2;
  localparam int LastStep    = 88;

  typedef enum logic {
    FuncHeader = 1'b0,
    FuncCode   = 1'b1
  } func_e;

  typedef enum logic [1:0] {
    CfgCodeBits     = 2'd0,
    CfgChannelCount = 2'd1,
    CfgGranularity  = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    func_e              func;
    logic               channel;
    logic [4:0]         code;
    logic signed [15:0] initial_predictor;
    logic [5:0]         initial_index;
  } in_word_t;

  typedef struct packed {
    logic signed [15:0] sample;
    logic               sample_channel;
    logic               last;
  } out_word_t;

  // Effective configuration after clamping.
  typedef struct packed {
    logic [2:0] nb;       // 2..5
    logic       dual;     // two channels
    logic [3:0] repeats;  // samples that follow a frame
  } cfg_t;

  // Decoded item handed to the output sequencer.
  typedef struct packed {
    logic signed [15:0] sample;
    logic               channel;
    logic               last;
    logic [3:0]         repeats;
    logic               dual;
    logic signed [15:0] snap0;
    logic signed [15:0] snap1;
  } frame_t;

  function automatic logic [14:0] step_size(input logic [6:0] idx);
    logic [14:0] s;
    unique case (idx)
      7'd0: s = 15'd7;      7'd1: s = 15'd8;      7'd2: s = 15'd9;      7'd3: s = 15'd10;
      7'd4: s = 15'd11;     7'd5: s = 15'd12;     7'd6: s = 15'd13;     7'd7: s = 15'd14;
      7'd8: s = 15'd16;     7'd9: s = 15'd17;     7'd10: s = 15'd19;    7'd11: s = 15'd21;
      7'd12: s = 15'd23;    7'd13: s = 15'd25;    7'd14: s = 15'd28;    7'd15: s = 15'd31;
      7'd16: s = 15'd34;    7'd17: s = 15'd37;    7'd18: s = 15'd41;    7'd19: s = 15'd45;
      7'd20: s = 15'd50;    7'd21: s = 15'd55;    7'd22: s = 15'd60;    7'd23: s = 15'd66;
      7'd24: s = 15'd73;    7'd25: s = 15'd80;    7'd26: s = 15'd88;    7'd27: s = 15'd97;
      7'd28: s = 15'd107;   7'd29: s = 15'd118;   7'd30: s = 15'd130;   7'd31: s = 15'd143;
      7'd32: s = 15'd157;   7'd33: s = 15'd173;   7'd34: s = 15'd190;   7'd35: s = 15'd209;
      7'd36: s = 15'd230;   7'd37: s = 15'd253;   7'd38: s = 15'd279;   7'd39: s = 15'd307;
      7'd40: s = 15'd337;   7'd41: s = 15'd371;   7'd42: s = 15'd408;   7'd43: s = 15'd449;
      7'd44: s = 15'd494;   7'd45: s = 15'd544;   7'd46: s = 15'd598;   7'd47: s = 15'd658;
      7'd48: s = 15'd724;   7'd49: s = 15'd796;   7'd50: s = 15'd876;   7'd51: s = 15'd963;
      7'd52: s = 15'd1060;  7'd53: s = 15'd1166;  7'd54: s = 15'd1282;  7'd55: s = 15'd1411;
      7'd56: s = 15'd1552;  7'd57: s = 15'd1707;  7'd58: s = 15'd1878;  7'd59: s = 15'd2066;
      7'd60: s = 15'd2272;  7'd61: s = 15'd2499;  7'd62: s = 15'd2749;  7'd63: s = 15'd3024;
      7'd64: s = 15'd3327;  7'd65: s = 15'd3660;  7'd66: s = 15'd4026;  7'd67: s = 15'd4428;
      7'd68: s = 15'd4871;  7'd69: s = 15'd5358;  7'd70: s = 15'd5894;  7'd71: s = 15'd6484;
      7'd72: s = 15'd7132;  7'd73: s = 15'd7845;  7'd74: s = 15'd8630;  7'd75: s = 15'd9493;
      7'd76: s = 15'd10442; 7'd77: s = 15'd11487; 7'd78: s = 15'd12635; 7'd79: s = 15'd13899;
      7'd80: s = 15'd15289; 7'd81: s = 15'd16818; 7'd82: s = 15'd18500; 7'd83: s = 15'd20350;
      7'd84: s = 15'd22385; 7'd85: s = 15'd24623; 7'd86: s = 15'd27086; 7'd87: s = 15'd29794;
      default: s = 15'd32767;
    endcase
    return s;
  endfunction

  // Index move; sel is code width minus two, mag the magnitude bits.
  function automatic logic signed [5:0] idx_adjust(input logic [1:0] sel,
                                                   input logic [3:0] mag);
    logic signed [5:0] a;
    a = -6'sd1;
    unique case (sel)
      2'd0: if (mag[0]) a = 6'sd2;
      2'd1: if (mag[1]) a = mag[0] ? 6'sd4 : 6'sd2;
      2'd2: begin
        if (mag[2]) begin
          case (mag[1:0])
            2'd0: a = 6'sd2;
            2'd1: a = 6'sd4;
            2'd2: a = 6'sd6;
            default: a = 6'sd8;
          endcase
        end
      end
      default: begin
        if (mag[3]) begin
          case (mag[2:0])
            3'd0: a = 6'sd1;
            3'd1: a = 6'sd2;
            3'd2: a = 6'sd4;
            3'd3: a = 6'sd6;
            3'd4: a = 6'sd8;
            3'd5: a = 6'sd10;
            3'd6: a = 6'sd13;
            default: a = 6'sd16;
          endcase
        end
      end
    endcase
    return a;
  endfunction

endpackage

### rtl/variable_width_adpcm_decoder.sv
// Top level of the variable-width ADPCM decoder.
//
//  channel   handshake             word           direction
//  --------  --------------------  -------------  ---------
//  input     in_valid_i/in_ready_o  in_word_i      in
//  output    out_valid_o/out_ready_i out_word_o    out
//  config    cfg_we_i               cfg_index_i/cfg_wdata_i  in
//
// An input word is registered, decoded combinationally and lands in the result
// register: one word a cycle unless the output stalls or repeats are pending.
// A word that ends a frame adds 2*granularity-channels repeats, one a cycle
// from a snapshot of both predictors; the input register holds one more word.
// Reset clears both channels' predictor and step index and loads 4-bit codes,
// mono, granularity 1. Output stalls hold the result and back up the input.
module variable_width_adpcm_decoder import vwad_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_word_t  in_word_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_word_t out_word_o,
  input  logic      cfg_we_i,
  input  logic [1:0] cfg_index_i,
  input  logic [3:0] cfg_wdata_i
);

  logic [2:0] code_bits_q;
  logic [1:0] channel_count_q;
  logic [3:0] granularity_q;

  cfg_t       cfg;
  logic [3:0] gran;
  logic [1:0] chans;
  logic [4:0] rep_full;

  logic       frame_valid;
  logic       emit_ready;
  frame_t     frame;

  // Register writes; unknown indexes drop.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      code_bits_q     <= 3'd4;
      channel_count_q <= 2'd1;
      granularity_q   <= 4'd1;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CfgCodeBits:     code_bits_q     <= cfg_wdata_i[2:0];
        CfgChannelCount: channel_count_q <= cfg_wdata_i[1:0];
        CfgGranularity:  granularity_q   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Clamp the registers into their working ranges.
  always_comb begin
    if (code_bits_q < 3'd2) cfg.nb = 3'd2;
    else if (code_bits_q > 3'd5) cfg.nb = 3'd5;
    else cfg.nb = code_bits_q;

    chans    = (channel_count_q >= 2'd2) ? 2'd2 : 2'd1;
    cfg.dual = (chans == 2'd2);

    if (granularity_q == 4'd0) gran = 4'd1;
    else if (granularity_q > 4'd8) gran = 4'd8;
    else gran = granularity_q;

    rep_full    = {gran, 1'b0} - {3'b000, chans};
    cfg.repeats = rep_full[3:0];
  end

  vwad_decode u_decode (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .in_word_i     (in_word_i),
    .cfg_i         (cfg),
    .emit_ready_i  (emit_ready),
    .frame_valid_o (frame_valid),
    .frame_o       (frame)
  );

  vwad_emit u_emit (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .frame_valid_i (frame_valid),
    .ready_o       (emit_ready),
    .frame_i       (frame),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_word_o    (out_word_o)
  );

endmodule

### rtl/vwad_decode.sv
// Input register, per-channel state and the one-pass ADPCM decode.
`include "variable_width_adpcm_decoder_defines.svh"

module vwad_decode import vwad_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  in_word_t in_word_i,
  input  cfg_t     cfg_i,
  input  logic     emit_ready_i,
  output logic     frame_valid_o,
  output frame_t   frame_o
);

  logic               in_valid_q;
  in_word_t           in_q;
  logic signed [15:0] pred_q [NumChannels];
  logic [6:0]         idx_q  [NumChannels];

  logic               ch;
  logic signed [15:0] cur_pred;
  logic [6:0]         si;
  logic [14:0]        step;
  logic               sign;
  logic [3:0]         mag;
  logic signed [5:0]  adj;
  logic signed [7:0]  ni;
  logic [16:0]        diff;
  logic signed [17:0] psum;
  logic signed [15:0] pred_d;
  logic [6:0]         idx_d;
  logic               ends_frame;
  logic               advance;

  assign advance       = in_valid_q && emit_ready_i;
  assign in_ready_o    = !in_valid_q || emit_ready_i;
  assign frame_valid_o = in_valid_q;
  assign ch            = in_q.channel;
  assign cur_pred      = pred_q[ch];

  always_comb begin
    int sh;
    si   = (idx_q[ch] > 7'(LastStep)) ? 7'(LastStep) : idx_q[ch];
    step = step_size(si);
    sign = in_q.code[cfg_i.nb - 3'd1];
    mag  = '0;
    for (int b = 0; b < 4; b++) begin
      if (b < int'(cfg_i.nb) - 1) mag[b] = in_q.code[b];
    end
    adj = idx_adjust(2'(cfg_i.nb - 3'd2), mag);
    ni  = $signed({1'b0, si}) + 8'(adj);

    // Sum shifted step copies for each set magnitude bit.
    diff = {2'b00, step} >> (cfg_i.nb - 3'd1);
    for (int b = 0; b < 4; b++) begin
      sh = int'(cfg_i.nb) - 2 - b;
      if (sh >= 0 && mag[b]) diff = diff + ({2'b00, step} >> sh);
    end
    psum = sign ? ({{2{cur_pred[15]}}, cur_pred} - $signed({1'b0, diff}))
                : ({{2{cur_pred[15]}}, cur_pred} + $signed({1'b0, diff}));

    if (in_q.func == FuncHeader) begin
      pred_d = in_q.initial_predictor;
      idx_d  = {1'b0, in_q.initial_index};
    end else begin
      if (psum < -18'sd32768) pred_d = -16'sd32768;
      else if (psum > 18'sd32767) pred_d = 16'sd32767;
      else pred_d = psum[15:0];
      if (ni < 8'sd0) idx_d = 7'd0;
      else if (ni > 8'(LastStep)) idx_d = 7'(LastStep);
      else idx_d = ni[6:0];
    end
  end

  assign ends_frame = cfg_i.dual ? ch : !ch;

  always_comb begin
    frame_o.sample  = pred_d;
    frame_o.channel = ch;
    frame_o.repeats = ends_frame ? cfg_i.repeats : 4'd0;
    frame_o.last    = !(ends_frame && (cfg_i.repeats != 4'd0));
    frame_o.dual    = cfg_i.dual;
    frame_o.snap0   = ch ? pred_q[0] : pred_d;
    frame_o.snap1   = ch ? pred_d : pred_q[1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_word_i;
    end
  end

  // Commit the channel state as the item leaves.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < NumChannels; c++) begin
        pred_q[c] <= '0;
        idx_q[c]  <= '0;
      end
    end else if (advance) begin
      pred_q[ch] <= pred_d;
      idx_q[ch]  <= idx_d;
    end
  end

  `VWAD_ASSERT_IMP(a_idx_range, 1'b1, idx_q[0] <= 7'(LastStep) && idx_q[1] <= 7'(LastStep))
  `VWAD_ASSERT_NXT(a_stall_hold, in_valid_q && !emit_ready_i, in_valid_q)
  `VWAD_ASSERT_NXT(a_state_hold, !advance, $stable(pred_q[0]) && $stable(pred_q[1]))

endmodule

### rtl/vwad_emit.sv
// Result register and repeat sequencer for frame upsampling.
`include "variable_width_adpcm_decoder_defines.svh"

module vwad_emit import vwad_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      frame_valid_i,
  output logic      ready_o,
  input  frame_t    frame_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_word_t out_word_o
);

  logic               valid_q;
  logic signed [15:0] sample_q;
  logic               chan_q;
  logic               last_q;
  logic [3:0]         rem_q;
  logic               k_q;
  logic               dual_q;
  logic signed [15:0] snap_q [NumChannels];
  logic               load;
  logic               step;

  assign ready_o = !valid_q || (out_ready_i && last_q);
  assign load    = frame_valid_i && ready_o;
  assign step    = valid_q && out_ready_i && !last_q;

  assign out_valid_o               = valid_q;
  assign out_word_o.sample         = sample_q;
  assign out_word_o.sample_channel = chan_q;
  assign out_word_o.last           = last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q   <= 1'b0;
      sample_q  <= '0;
      chan_q    <= 1'b0;
      last_q    <= 1'b1;
      rem_q     <= '0;
      k_q       <= 1'b0;
      dual_q    <= 1'b0;
      snap_q[0] <= '0;
      snap_q[1] <= '0;
    end else if (load) begin
      valid_q   <= 1'b1;
      sample_q  <= frame_i.sample;
      chan_q    <= frame_i.channel;
      last_q    <= frame_i.last;
      rem_q     <= frame_i.repeats;
      k_q       <= 1'b0;
      dual_q    <= frame_i.dual;
      snap_q[0] <= frame_i.snap0;
      snap_q[1] <= frame_i.snap1;
    end else if (step) begin
      sample_q <= snap_q[k_q];
      chan_q   <= k_q;
      last_q   <= (rem_q == 4'd1);
      rem_q    <= rem_q - 4'd1;
      k_q      <= dual_q ? !k_q : 1'b0;
    end else if (valid_q && out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  `VWAD_ASSERT_IMP(a_last_rem, valid_q, last_q == (rem_q == 4'd0))
  `VWAD_ASSERT_NXT(a_repeat_follows, step, valid_q)
  `VWAD_ASSERT_NXT(a_mono_channel, step && !dual_q, out_word_o.sample_channel == 1'b0)

endmodule
